FILE: hw/rtl/lsps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip streamer package
// Shared sizes, reset values, command and register codes, and the FSM states.
// ----------------------------------------------------------------------------
package lsps_pkg;

    // Frame store size and derived widths
    localparam int MAX_LEDS  = 256;
    localparam int LED_AW    = $clog2(MAX_LEDS);
    localparam int CNT_W     = $clog2(MAX_LEDS + 3);
    localparam int CMP_W     = (CNT_W + 1 > 9) ? CNT_W + 1 : 9;

    // Field widths
    localparam int CMD_W     = 3;
    localparam int IDX_W     = 8;
    localparam int CHAN_W    = 8;
    localparam int COLOUR_W  = 3 * CHAN_W;
    localparam int SLOT_W    = 6;
    localparam int DUTY_W    = 8;
    localparam int BIT_W     = 5;
    localparam int BRIGHT_W  = 7;
    localparam int LCOUNT_W  = 9;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    // Buffer geometry
    localparam int HALF_SLOTS = 24;
    localparam int ALL_SLOTS  = 48;

    // Register reset values
    localparam logic [BRIGHT_W-1:0] BRIGHT_RST = 7'd100;
    localparam logic [LCOUNT_W-1:0] LCOUNT_RST = 9'd256;
    localparam logic [DUTY_W-1:0]   ZERO_RST   = 8'd27;
    localparam logic [DUTY_W-1:0]   ONE_RST    = 8'd54;

    // Divide by 100 as multiply by reciprocal: exact for products below 43690
    localparam int                PROD_W      = CHAN_W + BRIGHT_W;
    localparam logic [15:0]       SCALE_MUL   = 16'd41944;
    localparam int                SCALE_SHIFT = 22;
    localparam int                RECIP_W     = PROD_W + 16;
    localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_LED   = 3'd0,
        CMD_CLEAR     = 3'd1,
        CMD_START     = 3'd2,
        CMD_HALF_DONE = 3'd3,
        CMD_FULL_DONE = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRIGHTNESS = 2'd0,
        CFG_LED_COUNT  = 2'd1,
        CFG_ZERO_TIME  = 2'd2,
        CFG_ONE_TIME   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_SCALE = 3'd1,
        S_WRITE = 3'd2,
        S_READ  = 3'd3,
        S_EMIT  = 3'd4
    } t_state;

endpackage

FILE: hw/rtl/led_strip_pulse_width_streamer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pulse-width streamer
// Frame store of LED colours turned into timer compare values, one per slot.
// ----------------------------------------------------------------------------
// A command is taken when i_start is high and o_busy is low. Results come one
// per cycle with o_valid high for exactly one cycle each and cannot be held
// off. After acceptance, set_led with an index in range keeps the block
// busy through the multiply stage, then the scale and store write; clear and
// ignored commands finish in the accept cycle. half_done and full_done give 24
// slots: a store read then 24 results, or 24 results at once when past the
// last LED. start, when no transfer runs, gives 48 slots: two store reads each
// followed by 24 results. The registered read of the colour store is why a
// read state comes ahead of each LED. After reset the frame store reads as all
// zeros at once; no clearing pass is run.
// ----------------------------------------------------------------------------
module led_strip_pulse_width_streamer
    import lsps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [IDX_W-1:0]     i_led_index,
    input  logic [CHAN_W-1:0]    i_red,
    input  logic [CHAN_W-1:0]    i_green,
    input  logic [CHAN_W-1:0]    i_blue,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    output logic [SLOT_W-1:0]    o_slot,
    output logic [DUTY_W-1:0]    o_duty,
    output logic                 o_last,
    output logic                 o_start_transfer,
    output logic                 o_stop_transfer,
    output logic                 o_busy_res
);

    // Configuration
    logic [BRIGHT_W-1:0] r_brightness;
    logic [LCOUNT_W-1:0] r_led_count;
    logic [DUTY_W-1:0]   r_zero_time;
    logic [DUTY_W-1:0]   r_one_time;

    // Control
    t_state              r_state;
    t_state              n_state;
    logic [MAX_LEDS-1:0] r_valid;
    logic [CNT_W-1:0]    r_next_led;
    logic                r_sending;
    logic [CNT_W-1:0]    r_led;
    logic                r_upper;
    logic                r_second;
    logic                r_zero;
    logic                r_is_start;
    logic                r_stop;
    logic [BIT_W-1:0]    r_bit;
    logic                r_hit;

    // Set_led payload
    logic [CHAN_W-1:0]   r_red;
    logic [CHAN_W-1:0]   r_green;
    logic [CHAN_W-1:0]   r_blue;
    logic [LED_AW-1:0]   r_waddr;

    // Derived
    t_cmd                w_cmd;
    logic                w_accept;
    logic [CNT_W-1:0]    w_n;
    logic [CMP_W-1:0]    w_n_wide;
    logic                w_idx_ok;
    logic                w_next_lt_n;
    logic                w_past_end;
    logic [CNT_W-1:0]    w_bump;
    logic                w_led_ok;
    logic [LED_AW-1:0]   w_raddr;
    logic                w_bit_last;
    logic [BIT_W-1:0]    w_bit_sel;
    logic [COLOUR_W-1:0] w_rdata;
    logic [COLOUR_W-1:0] w_grb;

    assign w_cmd    = t_cmd'(i_cmd);
    assign w_accept = i_start && (r_state == S_IDLE);

    // Clamp the LED count to the store depth
    assign w_n = (CMP_W'(r_led_count) > CMP_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS)
                                                           : CNT_W'(r_led_count);
    assign w_n_wide    = CMP_W'(w_n);
    assign w_idx_ok    = CMP_W'(i_led_index) < w_n_wide;
    assign w_next_lt_n = CMP_W'(r_next_led) < w_n_wide;
    assign w_past_end  = CMP_W'(r_next_led) >= (w_n_wide + CMP_W'(2));
    assign w_bump      = (r_next_led < CNT_W'(MAX_LEDS + 2)) ? r_next_led + CNT_W'(1)
                                                              : r_next_led;
    assign w_led_ok    = CMP_W'(r_led) < w_n_wide;
    assign w_raddr     = r_led[LED_AW-1:0];
    assign w_bit_last  = (r_bit == BIT_W'(HALF_SLOTS - 1));
    assign w_bit_sel   = BIT_W'(HALF_SLOTS - 1) - r_bit;

    // Colour scaler
    lsps_scale u_scale (
        .i_clk        (i_clk),
        .i_brightness (r_brightness),
        .i_red        (r_red),
        .i_green      (r_green),
        .i_blue       (r_blue),
        .o_grb        (w_grb)
    );

    // Frame store
    lsps_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (MAX_LEDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WRITE),
        .i_waddr (r_waddr),
        .i_wdata (w_grb),
        .i_re    (r_state == S_READ),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_cmd)
                        CMD_SET_LED: begin
                            if (w_idx_ok) begin
                                n_state = S_SCALE;
                            end
                        end
                        CMD_START: begin
                            if (!r_sending) begin
                                n_state = S_READ;
                            end
                        end
                        CMD_HALF_DONE, CMD_FULL_DONE: begin
                            n_state = w_next_lt_n ? S_READ : S_EMIT;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCALE: n_state = S_WRITE;
            S_WRITE: n_state = S_IDLE;
            S_READ:  n_state = S_EMIT;
            S_EMIT: begin
                if (w_bit_last) begin
                    n_state = r_second ? S_READ : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_busy           = (r_state != S_IDLE);
        o_valid          = (r_state == S_EMIT);
        o_slot           = r_upper ? SLOT_W'(HALF_SLOTS) + SLOT_W'(r_bit) : SLOT_W'(r_bit);
        o_last           = o_valid && w_bit_last && !r_second;
        o_start_transfer = o_last && r_is_start;
        o_stop_transfer  = o_last && r_stop;
        o_busy_res       = r_sending;
        if (r_zero) begin
            o_duty = '0;
        end else if (r_hit && w_rdata[w_bit_sel]) begin
            o_duty = r_one_time;
        end else begin
            o_duty = r_zero_time;
        end
    end

    // Control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_next_led   <= '0;
            r_sending    <= 1'b0;
            r_led        <= '0;
            r_upper      <= 1'b0;
            r_second     <= 1'b0;
            r_zero       <= 1'b0;
            r_is_start   <= 1'b0;
            r_stop       <= 1'b0;
            r_bit        <= '0;
            r_hit        <= 1'b0;
            r_brightness <= BRIGHT_RST;
            r_led_count  <= LCOUNT_RST;
            r_zero_time  <= ZERO_RST;
            r_one_time   <= ONE_RST;
        end else begin
            r_state <= n_state;

            // Take register writes
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_BRIGHTNESS: r_brightness <= i_cfg_data[BRIGHT_W-1:0];
                    CFG_LED_COUNT:  r_led_count  <= i_cfg_data[LCOUNT_W-1:0];
                    CFG_ZERO_TIME:  r_zero_time  <= i_cfg_data[DUTY_W-1:0];
                    CFG_ONE_TIME:   r_one_time   <= i_cfg_data[DUTY_W-1:0];
                    default: ;
                endcase
            end

            // Decode an accepted command
            if (w_accept) begin
                case (w_cmd)
                    CMD_CLEAR: begin
                        for (int i = 0; i < MAX_LEDS; i++) begin
                            if (CMP_W'(i) < w_n_wide) begin
                                r_valid[i] <= 1'b0;
                            end
                        end
                    end
                    CMD_START: begin
                        if (!r_sending) begin
                            r_led      <= '0;
                            r_upper    <= 1'b0;
                            r_second   <= 1'b1;
                            r_zero     <= 1'b0;
                            r_is_start <= 1'b1;
                            r_stop     <= 1'b0;
                            r_bit      <= '0;
                            r_next_led <= CNT_W'(2);
                            r_sending  <= 1'b1;
                        end
                    end
                    CMD_HALF_DONE: begin
                        r_led      <= r_next_led;
                        r_upper    <= 1'b0;
                        r_second   <= 1'b0;
                        r_zero     <= !w_next_lt_n;
                        r_is_start <= 1'b0;
                        r_stop     <= 1'b0;
                        r_bit      <= '0;
                        if (w_next_lt_n) begin
                            r_next_led <= w_bump;
                        end
                    end
                    CMD_FULL_DONE: begin
                        r_led      <= r_next_led;
                        r_upper    <= 1'b1;
                        r_second   <= 1'b0;
                        r_zero     <= !w_next_lt_n;
                        r_is_start <= 1'b0;
                        r_stop     <= !w_next_lt_n && w_past_end;
                        r_bit      <= '0;
                        r_next_led <= w_bump;
                        if (!w_next_lt_n && w_past_end) begin
                            r_sending <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end

            // Mark the stored entry as written
            if (r_state == S_WRITE) begin
                r_valid[r_waddr] <= 1'b1;
            end

            // Latch whether the fetched entry holds a colour
            if (r_state == S_READ) begin
                r_hit <= w_led_ok && r_valid[w_raddr];
            end

            // Advance through the slots, then move to the second LED of a start
            if (r_state == S_EMIT) begin
                if (w_bit_last) begin
                    r_bit <= '0;
                    if (r_second) begin
                        r_second <= 1'b0;
                        r_upper  <= 1'b1;
                        r_led    <= r_led + CNT_W'(1);
                    end
                end else begin
                    r_bit <= r_bit + BIT_W'(1);
                end
            end
        end
    end

    // Hold the set_led word for the scaler
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_cmd == CMD_SET_LED)) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_waddr <= LED_AW'(i_led_index);
        end
    end

endmodule

FILE: hw/rtl/lsps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lsps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, hold when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/lsps_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brightness scaler
// Two stages: channel times brightness, then divide by 100 and saturate.
// Output word is packed green, red, blue.
// ----------------------------------------------------------------------------
module lsps_scale
    import lsps_pkg::*;
(
    input  logic                i_clk,
    input  logic [BRIGHT_W-1:0] i_brightness,
    input  logic [CHAN_W-1:0]   i_red,
    input  logic [CHAN_W-1:0]   i_green,
    input  logic [CHAN_W-1:0]   i_blue,
    output logic [COLOUR_W-1:0] o_grb
);

    logic [PROD_W-1:0] r_prod_red;
    logic [PROD_W-1:0] r_prod_green;
    logic [PROD_W-1:0] r_prod_blue;

    // Divide a product by 100 and clamp to one channel
    function automatic logic [CHAN_W-1:0] div_sat(input logic [PROD_W-1:0] p);
        logic [RECIP_W-1:0]             q;
        logic [RECIP_W-SCALE_SHIFT-1:0] v;
        q = RECIP_W'(p) * RECIP_W'(SCALE_MUL);
        v = q[RECIP_W-1:SCALE_SHIFT];
        return (v > (RECIP_W - SCALE_SHIFT)'(CHAN_MAX)) ? CHAN_MAX : v[CHAN_W-1:0];
    endfunction

    // Stage one: register the products
    always_ff @(posedge i_clk) begin
        r_prod_red   <= PROD_W'(i_red)   * PROD_W'(i_brightness);
        r_prod_green <= PROD_W'(i_green) * PROD_W'(i_brightness);
        r_prod_blue  <= PROD_W'(i_blue)  * PROD_W'(i_brightness);
    end

    // Stage two: reciprocal multiply feeding the store write
    assign o_grb = {div_sat(r_prod_green), div_sat(r_prod_red), div_sat(r_prod_blue)};

endmodule

FILE: hw/rtl/lsps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip streamer checker
// Port-level checks on result bursts, bound to the top level.
// ----------------------------------------------------------------------------
module lsps_checker
    import lsps_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_busy,
    input logic                 o_valid,
    input logic [SLOT_W-1:0]    o_slot,
    input logic                 o_last,
    input logic                 o_start_transfer,
    input logic                 o_stop_transfer,
    input logic                 o_busy_res
);

    // Words only appear while a command is in progress
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("result word outside a busy period");

    // Slots within a half run back to back in order
    a_slot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last && (o_slot != SLOT_W'(HALF_SLOTS - 1)))
        |=> (o_valid && (o_slot == $past(o_slot) + SLOT_W'(1))))
        else $error("slot sequence broken");

    // A burst ends with the block free again
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> (!o_valid && !o_busy))
        else $error("activity after the last word");

    // Start flag only on the final slot of the full buffer
    a_start_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_start_transfer |-> (o_last && (o_slot == SLOT_W'(ALL_SLOTS - 1)) && o_busy_res))
        else $error("start flag misplaced");

    // Stop flag only on a last word with the transfer ended
    a_stop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stop_transfer |-> (o_last && !o_busy_res))
        else $error("stop flag with transfer still running");

endmodule

bind led_strip_pulse_width_streamer lsps_checker u_lsps_checker (.*);

FILE: tb/sv/led_strip_pulse_width_streamer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pulse-width streamer testbench
// Sends set_led, clear, start and DMA half/full done commands in random bursts
// and checks every compare-slot word against a colour store and LED cursor
// kept in the bench. Covers directed corner cases, then random transfers
// over many strip lengths, brightness values and bit timings.
// ----------------------------------------------------------------------------
module led_strip_pulse_width_streamer_tb;
    import lsps_pkg::*;

    // Command codes the block does not define
    localparam logic [CMD_W-1:0] CMD_RESERVED_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RESERVED_7 = 3'd7;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [DUTY_W-1:0] duty;
        logic              last;
        logic              start_tr;
        logic              stop_tr;
        logic              busy_r;
    } slot_word_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    logic                 o_busy;
    logic [CMD_W-1:0]     i_cmd = '0;
    logic [IDX_W-1:0]     i_led_index = '0;
    logic [CHAN_W-1:0]    i_red = '0;
    logic [CHAN_W-1:0]    i_green = '0;
    logic [CHAN_W-1:0]    i_blue = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_valid;
    logic [SLOT_W-1:0]    o_slot;
    logic [DUTY_W-1:0]    o_duty;
    logic                 o_last;
    logic                 o_start_transfer;
    logic                 o_stop_transfer;
    logic                 o_busy_res;

    // Bench copy of the block state and registers
    logic [COLOUR_W-1:0] led_colours [MAX_LEDS];
    int unsigned         led_cursor = 0;
    bit                  strip_active = 1'b0;
    logic [BRIGHT_W-1:0] cfg_bright = BRIGHT_RST;
    logic [LCOUNT_W-1:0] cfg_count = LCOUNT_RST;
    logic [DUTY_W-1:0]   cfg_zero = ZERO_RST;
    logic [DUTY_W-1:0]   cfg_one = ONE_RST;

    slot_word_t slot_burst[$];
    slot_word_t slot_words_due[$];
    int         err_count = 0;
    int         rand_items = 0;
    bit         gaps_on = 1'b1;
    int         burst_left = 0;

    led_strip_pulse_width_streamer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_cmd            (i_cmd),
        .i_led_index      (i_led_index),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_slot           (o_slot),
        .o_duty           (o_duty),
        .o_last           (o_last),
        .o_start_transfer (o_start_transfer),
        .o_stop_transfer  (o_stop_transfer),
        .o_busy_res       (o_busy_res)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < MAX_LEDS; i++) led_colours[i] = '0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_REPORTS)
            $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
        err_count++;
    endtask

    // ---------------- predictor ----------------

    function automatic int unsigned active_leds();
        return (cfg_count > MAX_LEDS) ? MAX_LEDS : int'(cfg_count);
    endfunction

    function automatic logic [CHAN_W-1:0] scale_channel(input logic [CHAN_W-1:0] chan);
        int unsigned prod;
        prod = (int'(chan) * int'(cfg_bright)) / 100;
        return (prod > 255) ? CHAN_MAX : prod[CHAN_W-1:0];
    endfunction

    function automatic void advance_cursor();
        if (led_cursor < MAX_LEDS + 2) led_cursor++;
    endfunction

    // Queue 24 bit times of one LED, MSB first; LEDs past the strip send zeros
    function automatic void add_led_bits(input int unsigned base, input int unsigned led);
        logic [COLOUR_W-1:0] grb;
        slot_word_t          w;
        grb = '0;
        if (led < active_leds()) grb = led_colours[led];
        for (int i = 0; i < HALF_SLOTS; i++) begin
            w = '0;
            w.slot = SLOT_W'(base + i);
            w.duty = grb[COLOUR_W-1-i] ? cfg_one : cfg_zero;
            slot_burst.push_back(w);
        end
    endfunction

    // Queue one half of latch gap
    function automatic void add_latch_gap(input int unsigned base);
        slot_word_t w;
        for (int i = 0; i < HALF_SLOTS; i++) begin
            w = '0;
            w.slot = SLOT_W'(base + i);
            slot_burst.push_back(w);
        end
    endfunction

    function automatic void predict_slots(input logic [CMD_W-1:0] cmd,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [CHAN_W-1:0] red,
                                          input logic [CHAN_W-1:0] green,
                                          input logic [CHAN_W-1:0] blue);
        int unsigned n;
        bit          begins;
        bit          ends;
        slot_word_t  w;
        n = active_leds();
        begins = 1'b0;
        ends = 1'b0;
        slot_burst.delete();
        case (cmd)
            CMD_SET_LED: begin
                if (idx < n)
                    led_colours[idx] = {scale_channel(green), scale_channel(red),
                                        scale_channel(blue)};
            end
            CMD_CLEAR: begin
                for (int i = 0; i < n; i++) led_colours[i] = '0;
            end
            CMD_START: begin
                if (!strip_active) begin
                    add_led_bits(0, 0);
                    add_led_bits(HALF_SLOTS, 1);
                    led_cursor = 2;
                    strip_active = 1'b1;
                    begins = 1'b1;
                end
            end
            CMD_HALF_DONE: begin
                if (led_cursor < n) begin
                    add_led_bits(0, led_cursor);
                    advance_cursor();
                end else begin
                    add_latch_gap(0);
                end
            end
            CMD_FULL_DONE: begin
                if (led_cursor < n) begin
                    add_led_bits(HALF_SLOTS, led_cursor);
                end else begin
                    add_latch_gap(HALF_SLOTS);
                    if (led_cursor >= n + 2) begin
                        ends = 1'b1;
                        strip_active = 1'b0;
                    end
                end
                advance_cursor();
            end
            default: ;
        endcase
        // Tag the words with busy state and end-of-command flags
        for (int k = 0; k < slot_burst.size(); k++) begin
            w = slot_burst[k];
            w.busy_r = strip_active;
            if (k == slot_burst.size() - 1) begin
                w.last = 1'b1;
                w.start_tr = begins;
                w.stop_tr = ends;
            end
            slot_words_due.push_back(w);
        end
    endfunction

    // ---------------- checker ----------------

    // Compare each result word with the oldest expected word
    always @(posedge i_clk) begin : check_words
        slot_word_t want;
        if (i_rst_n && o_valid) begin
            if (slot_words_due.size() == 0) begin
                report_mismatch("word with none expected, slot", o_slot, 0);
            end else begin
                want = slot_words_due.pop_front();
                if (o_slot !== want.slot) report_mismatch("slot", o_slot, want.slot);
                if (o_duty !== want.duty) report_mismatch("duty", o_duty, want.duty);
                if (o_last !== want.last) report_mismatch("last", o_last, want.last);
                if (o_start_transfer !== want.start_tr)
                    report_mismatch("start_transfer", o_start_transfer, want.start_tr);
                if (o_stop_transfer !== want.stop_tr)
                    report_mismatch("stop_transfer", o_stop_transfer, want.stop_tr);
                if (o_busy_res !== want.busy_r)
                    report_mismatch("busy_res", o_busy_res, want.busy_r);
            end
        end
    end

    // ---------------- drivers ----------------

    // Send one command word; entered and left at a falling edge
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
                             input logic [CHAN_W-1:0] blue);
        i_cmd = cmd;
        i_led_index = idx;
        i_red = red;
        i_green = green;
        i_blue = blue;
        i_start = 1'b1;
        while (o_busy) @(negedge i_clk);
        @(negedge i_clk);
        predict_slots(cmd, idx, red, green, blue);
        i_start = 1'b0;
        // Insert a random gap at the end of each burst
        if (gaps_on) begin
            if (burst_left == 0) begin
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                burst_left = $urandom_range(1, 8);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_random_colour(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
        send_word(cmd, idx, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255));
    endtask

    // Wait for all expected words, then let a trailing set_led finish
    task automatic wait_idle();
        int guard;
        guard = 0;
        while (slot_words_due.size() != 0 && guard < 2000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx which, input int unsigned value);
        i_cfg_we = 1'b1;
        i_cfg_idx = which;
        i_cfg_data = CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (which)
            CFG_BRIGHTNESS: cfg_bright = value[BRIGHT_W-1:0];
            CFG_LED_COUNT:  cfg_count = value[LCOUNT_W-1:0];
            CFG_ZERO_TIME:  cfg_zero = value[DUTY_W-1:0];
            CFG_ONE_TIME:   cfg_one = value[DUTY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned bright, input int unsigned count,
                              input int unsigned zero_t, input int unsigned one_t);
        wait_idle();
        write_reg(CFG_BRIGHTNESS, bright);
        write_reg(CFG_LED_COUNT, count);
        write_reg(CFG_ZERO_TIME, zero_t);
        write_reg(CFG_ONE_TIME, one_t);
    endtask

    // ---------------- tests ----------------

    // Default registers: colour extremes, start, repeated start, done events, reserved codes, clear
    task automatic test_set_and_start();
        send_word(CMD_SET_LED, 8'd0, 8'hFF, 8'h00, 8'hAA);
        send_word(CMD_SET_LED, 8'd255, 8'h00, 8'hFF, 8'h55);
        send_word(CMD_SET_LED, 8'd1, 8'h81, 8'h7E, 8'h01);
        send_word(CMD_START, 8'd0, 8'h00, 8'h00, 8'h00);
        send_word(CMD_START, 8'd0, 8'h00, 8'h00, 8'h00);
        send_word(CMD_HALF_DONE, 8'd0, 8'h00, 8'h00, 8'h00);
        send_word(CMD_FULL_DONE, 8'd0, 8'h00, 8'h00, 8'h00);
        send_word(CMD_RESERVED_5, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(CMD_RESERVED_7, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(CMD_CLEAR, 8'd0, 8'h00, 8'h00, 8'h00);
    endtask

    // Two-LED strip, saturating brightness, end of transfer and idle done events
    task automatic test_short_strip_saturation();
        set_config(127, 2, 0, 255);
        send_word(CMD_SET_LED, 8'd2, 8'hFF, 8'hFF, 8'hFF);
        send_word(CMD_SET_LED, 8'd1, 8'hFF, 8'hFF, 8'hFF);
        send_word(CMD_SET_LED, 8'd0, 8'd100, 8'd1, 8'd200);
        send_word(CMD_FULL_DONE, 8'd0, 8'h00, 8'h00, 8'h00);
        send_word(CMD_HALF_DONE, 8'd0, 8'h00, 8'h00, 8'h00);
        send_word(CMD_START, 8'd0, 8'h00, 8'h00, 8'h00);
        send_word(CMD_FULL_DONE, 8'd0, 8'h00, 8'h00, 8'h00);
        send_word(CMD_HALF_DONE, 8'd0, 8'h00, 8'h00, 8'h00);
        send_word(CMD_FULL_DONE, 8'd0, 8'h00, 8'h00, 8'h00);
        send_word(CMD_FULL_DONE, 8'd0, 8'h00, 8'h00, 8'h00);
    endtask

    // Empty strip, then a count beyond the store size with zero brightness
    task automatic test_empty_and_oversize_count();
        set_config(0, 0, 255, 0);
        send_word(CMD_SET_LED, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        send_word(CMD_CLEAR, 8'd0, 8'h00, 8'h00, 8'h00);
        send_word(CMD_START, 8'd0, 8'h00, 8'h00, 8'h00);
        send_word(CMD_FULL_DONE, 8'd0, 8'h00, 8'h00, 8'h00);
        set_config(0, 511, 27, 54);
        send_word(CMD_SET_LED, 8'd255, 8'hFF, 8'hFF, 8'hFF);
        send_word(CMD_START, 8'd0, 8'h00, 8'h00, 8'h00);
        send_word(CMD_HALF_DONE, 8'd0, 8'h00, 8'h00, 8'h00);
    endtask

    // Random frames and DMA event sequences over many register settings
    task automatic test_random_transfers();
        int unsigned ph;
        int unsigned cnt;
        int unsigned bright;
        int unsigned zero_t;
        int unsigned one_t;
        int unsigned n_sets;
        logic [IDX_W-1:0] idx;
        logic [CMD_W-1:0] cmd;
        ph = 0;
        while (rand_items < 250) begin
            // Pick the strip length: mostly short, rarely long
            if (ph == 0) cnt = 1;
            else if (ph == 2) cnt = MAX_LEDS;
            else if ($urandom_range(0, 7) == 0) cnt = $urandom_range(1, MAX_LEDS);
            else cnt = $urandom_range(1, 6);
            case ($urandom_range(0, 5))
                0: bright = 0;
                1: bright = 100;
                2: bright = 127;
                default: bright = $urandom_range(0, 100);
            endcase
            zero_t = (ph % 4 == 1) ? 0 : (ph % 4 == 3) ? 255 : $urandom_range(0, 255);
            one_t = (ph % 4 == 1) ? 255 : (ph % 4 == 3) ? 0 : $urandom_range(0, 255);
            set_config(bright, cnt, zero_t, one_t);
            gaps_on = ($urandom_range(0, 3) != 0);

            // Load a few LEDs, now and then wiping the frame
            n_sets = $urandom_range(1, 5);
            for (int s = 0; s < n_sets; s++) begin
                if ($urandom_range(0, 4) == 0) idx = $urandom_range(0, 255);
                else idx = $urandom_range(0, cnt - 1);
                send_random_colour(CMD_SET_LED, idx);
                rand_items++;
                if ($urandom_range(0, 9) == 0) begin
                    send_random_colour(CMD_CLEAR, $urandom_range(0, 255));
                    rand_items++;
                end
            end
            send_random_colour(CMD_START, $urandom_range(0, 255));
            rand_items++;

            // Alternate half and full done until the transfer ends
            for (int k = 0; k < 30 && strip_active; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_random_colour($urandom_range(0, 7), $urandom_range(0, 255));
                end else begin
                    if ($urandom_range(0, 7) == 0)
                        cmd = ($urandom_range(0, 1) != 0) ? CMD_FULL_DONE : CMD_HALF_DONE;
                    else
                        cmd = k[0] ? CMD_FULL_DONE : CMD_HALF_DONE;
                    send_random_colour(cmd, $urandom_range(0, 255));
                    rand_items++;
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                cmd = ($urandom_range(0, 1) != 0) ? CMD_FULL_DONE : CMD_HALF_DONE;
                send_random_colour(cmd, $urandom_range(0, 255));
                rand_items++;
            end
            ph++;
        end
    endtask

    // ---------------- sequence ----------------

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_set_and_start();
        test_short_strip_saturation();
        test_empty_and_oversize_count();
        test_random_transfers();
        wait_idle();
        repeat (60) @(negedge i_clk);
        if (slot_words_due.size() != 0)
            report_mismatch("expected words never seen", 0, slot_words_due.size());
        if (err_count == 0) begin
            $display("led_strip_pulse_width_streamer: match");
        end else begin
            $display("led_strip_pulse_width_streamer: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("led_strip_pulse_width_streamer: mismatch");
        $finish;
    end

endmodule

FILE: led_strip_pulse_width_streamer.f
hw/rtl/lsps_pkg.sv
hw/rtl/lsps_ram.sv
hw/rtl/lsps_scale.sv
hw/rtl/led_strip_pulse_width_streamer.sv
hw/rtl/lsps_checker.sv
tb/sv/led_strip_pulse_width_streamer_tb.sv
